[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression never true out of reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[hw/rtl/tdae_pkg.sv]
// ----------------------------------------------------------------------------
// tdae_pkg
// mode codes, register indexes, constants and stage types of the downscaler
// ----------------------------------------------------------------------------
package tdae_pkg;

  localparam logic [1:0] MODE_RGBA_HALF  = 2'd0;
  localparam logic [1:0] MODE_ALPHA_FULL = 2'd1;
  localparam logic [1:0] MODE_ALPHA_HALF = 2'd2;

  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_WIDTH   = 2'd1;
  localparam logic [1:0] REG_PRESENT = 2'd2;

  localparam int          CFG_DW      = 13;
  localparam logic [31:0] ALPHA_WHITE = 32'h00ff_ffff;
  localparam int          LANE_W      = 9;
  localparam int          PS_W        = 4 * LANE_W;

  localparam logic [1:0]        RST_MODE    = MODE_RGBA_HALF;
  localparam logic [CFG_DW-1:0] RST_WIDTH   = 13'd4096;
  localparam logic              RST_PRESENT = 1'b1;

  // request held between line store read and the output register
  typedef struct packed {
    logic [1:0]      kind;
    logic [31:0]     pix;
    logic [PS_W-1:0] ps;
    logic            present;
    logic            row_end;
  } stage_t;

  function automatic logic [31:0] white_alpha(input logic [7:0] a);
    return ALPHA_WHITE | {a, 24'h0};
  endfunction

  function automatic logic [PS_W-1:0] lane_sum(input logic [31:0] a, input logic [31:0] b);
    logic [PS_W-1:0] r;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      r[c*LANE_W +: LANE_W] = {1'b0, a[c*8 +: 8]} + {1'b0, b[c*8 +: 8]};
    end
    return r;
  endfunction

endpackage

[hw/rtl/texture_downscale_alpha_expand.sv]
// ----------------------------------------------------------------------------
// texture_downscale_alpha_expand
// 2x2 box downscaler for rgba words and alpha expander to white pixels
//
//   channel  direction  ports
//   in       request    in_valid in_stall in_sample in_frame_start
//   out      result     out_valid out_stall out_pixel out_row_end
//   cfg      write      cfg_we cfg_index cfg_wdata
//
// one source pixel per cycle while in_stall is low; a result passes the middle stage, then the output register
// the line store takes at most one read or one write per request, no clearing pass
// reset is synchronous; the line store has no reset and holds what was written
// a stalled output holds its result while one more request enters the middle
// stage; in_stall rises only when both stages hold results
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module texture_downscale_alpha_expand #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [31:0]                in_sample,
  input  logic                       in_frame_start,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [31:0]                out_pixel,
  output logic                       out_row_end,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [tdae_pkg::CFG_DW-1:0] cfg_wdata
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CW0 = $clog2(MAX_WIDTH);
  localparam int CW  = (CW0 > AW + 1) ? CW0 : AW + 1;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int EW  = ((CW > WW) ? CW : WW) + 1;
  localparam int PSW = tdae_pkg::PS_W;
  localparam int LW  = tdae_pkg::LANE_W;

  // configuration
  logic [1:0]                  mode_r;
  logic [tdae_pkg::CFG_DW-1:0] width_r;
  logic                        present_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= tdae_pkg::RST_MODE;
      width_r   <= tdae_pkg::RST_WIDTH;
      present_r <= tdae_pkg::RST_PRESENT;
    end else if (cfg_we) begin
      case (cfg_index)
        tdae_pkg::REG_MODE:    mode_r    <= cfg_wdata[1:0];
        tdae_pkg::REG_WIDTH:   width_r   <= cfg_wdata;
        tdae_pkg::REG_PRESENT: present_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // handshake
  logic   s1_valid_r, s1_valid_nxt;
  tdae_pkg::stage_t s1_r, s1_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic [31:0] out_pixel_r, out_pixel_nxt;
  logic   out_row_end_r, out_row_end_nxt;
  logic   out_free, s1_free, accept;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_free  = !s1_valid_r || out_free;
  assign in_stall = !s1_free;
  assign accept   = in_valid && s1_free;

  // position
  logic [CW-1:0] col_r, col_nxt;
  logic          odd_r, odd_nxt;
  logic [31:0]   left_r, left_nxt;
  logic [WW-1:0] w_eff, out_w;
  logic [CW-1:0] x;
  logic          odd_row, last, half_ok, row_end_h;
  logic          is_full, is_alpha;
  logic [PSW-1:0] ps;
  logic [7:0]    full_a;

  always_comb begin
    if (width_r == '0 || 32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    out_w     = w_eff >> 1;
    x         = in_frame_start ? '0 : col_r;
    odd_row   = in_frame_start ? 1'b0 : odd_r;
    last      = EW'(x) >= (EW'(w_eff) - EW'(1));
    half_ok   = EW'(x >> 1) < EW'(out_w);
    row_end_h = EW'(x >> 1) == (EW'(out_w) - EW'(1));
    is_full   = mode_r == tdae_pkg::MODE_ALPHA_FULL;
    is_alpha  = mode_r == tdae_pkg::MODE_ALPHA_HALF;
    full_a    = present_r ? in_sample[7:0] : 8'h00;
    if (is_alpha) begin
      ps = PSW'({1'b0, left_r[7:0]} + {1'b0, in_sample[7:0]});
    end else begin
      ps = tdae_pkg::lane_sum(left_r, in_sample);
    end
  end

  // line store access
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_addr;
  logic [PSW-1:0] ram_rdata;

  assign ram_addr = x[AW:1];

  always_comb begin
    col_nxt      = col_r;
    odd_nxt      = odd_r;
    left_nxt     = left_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    s1_valid_nxt = s1_valid_r && !out_free;
    s1_nxt       = s1_r;
    if (accept) begin
      col_nxt = last ? '0 : x + CW'(1);
      odd_nxt = last ? !odd_row : odd_row;
      if (is_full) begin
        s1_valid_nxt   = 1'b1;
        s1_nxt.kind    = tdae_pkg::MODE_ALPHA_FULL;
        s1_nxt.pix     = tdae_pkg::white_alpha(full_a);
        s1_nxt.row_end = last;
      end else if (half_ok) begin
        if (!x[0]) begin
          left_nxt = in_sample;
        end else if (!odd_row) begin
          ram_we = 1'b1;
        end else begin
          ram_re         = 1'b1;
          s1_valid_nxt   = 1'b1;
          s1_nxt.kind    = is_alpha ? tdae_pkg::MODE_ALPHA_HALF : tdae_pkg::MODE_RGBA_HALF;
          s1_nxt.ps      = ps;
          s1_nxt.present = present_r;
          s1_nxt.row_end = row_end_h;
        end
      end
    end
  end

  tdae_line_ram #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW),
    .DW    (PSW)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ps),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // vertical sum and output register
  logic [9:0]  a_sum;
  logic [31:0] half_pix;

  always_comb begin
    logic [LW:0] s;
    a_sum    = {1'b0, ram_rdata[LW-1:0]} + {1'b0, s1_r.ps[LW-1:0]};
    half_pix = '0;
    for (int c = 0; c < 4; c++) begin
      s = {1'b0, ram_rdata[c*LW +: LW]} + {1'b0, s1_r.ps[c*LW +: LW]};
      half_pix[c*8 +: 8] = s[9:2];
    end
    out_valid_nxt   = out_valid_r && out_stall;
    out_pixel_nxt   = out_pixel_r;
    out_row_end_nxt = out_row_end_r;
    if (s1_valid_r && out_free) begin
      out_valid_nxt   = 1'b1;
      out_row_end_nxt = s1_r.row_end;
      case (s1_r.kind)
        tdae_pkg::MODE_ALPHA_FULL: out_pixel_nxt = s1_r.pix;
        tdae_pkg::MODE_ALPHA_HALF:
          out_pixel_nxt = tdae_pkg::white_alpha(s1_r.present ? a_sum[9:2] : 8'h00);
        default: out_pixel_nxt = half_pix;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      odd_r       <= 1'b0;
      left_r      <= '0;
      s1_valid_r  <= 1'b0;
      s1_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      odd_r       <= odd_nxt;
      left_r      <= left_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s1_r        <= s1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_r   <= out_pixel_nxt;
    out_row_end_r <= out_row_end_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_pixel   = out_pixel_r;
  assign out_row_end = out_row_end_r;

  `ASSERT_NEVER(a_ram_one_port, ram_we && ram_re, "line store read and write in one cycle")
  `ASSERT_CLK(a_read_to_stage, ram_re |=> s1_valid_r, "line store read without a held request")
  `ASSERT_CLK(a_stage_hold, s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_r),
              "held request lost while output stalled")

endmodule

[hw/rtl/tdae_line_ram.sv]
// ----------------------------------------------------------------------------
// tdae_line_ram
// line store of even-row pair sums, one write and one registered read port
// ----------------------------------------------------------------------------
module tdae_line_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 36
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[tb/sv/tb_texture_downscale_alpha_expand.sv]
// ----------------------------------------------------------------------------
// tb_texture_downscale_alpha_expand
// self-checking bench for the 2x2 box downscaler and alpha expander
//
// every accepted request is run through a local model of the block and the
// expected pixel, if any, is queued; results are checked in order against the
// queue. directed cases cover pixel extremes, all mode codes, dropped odd
// edges, absent source, width shrink and the width extremes, then random
// frames run under three stall profiles
// ----------------------------------------------------------------------------
module tb_texture_downscale_alpha_expand;

  localparam int         SRC_MAX         = 4096;
  localparam int         CFG_W           = tdae_pkg::CFG_DW;
  localparam int         DRAIN_CYCLES    = 8;
  localparam int         ROUND_REQUESTS  = 330;
  localparam int         EXTREME_COLS    = 64;
  localparam logic [1:0] MODE_RGBA_ALIAS = 2'd3;

  typedef struct {
    logic [31:0] pixel;
    logic        row_end;
  } out_pixel_t;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic [31:0]       in_sample      = '0;
  logic              in_frame_start = 1'b0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [31:0]       out_pixel;
  logic              out_row_end;
  logic              cfg_we         = 1'b0;
  logic [1:0]        cfg_index      = tdae_pkg::REG_MODE;
  logic [CFG_W-1:0]  cfg_wdata      = '0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned mismatch_count = 0;
  int unsigned sent_count     = 0;

  // model state
  logic [1:0]                mode_q;
  logic [CFG_W-1:0]          width_q;
  logic                      present_q;
  logic [11:0]               col_q;
  logic                      odd_q;
  logic [31:0]               left_q;
  logic [tdae_pkg::PS_W-1:0] pair_sums [SRC_MAX/2];

  out_pixel_t pending_pixels[$];

  always #5 clk = ~clk;

  texture_downscale_alpha_expand #(
    .MAX_WIDTH(SRC_MAX)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .in_frame_start(in_frame_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel     (out_pixel),
    .out_row_end   (out_row_end),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    out_pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual pixel %h row_end %b",
                 $time, out_pixel, out_row_end);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel !== want.pixel) begin
          $display("%0t: pixel mismatch, expected %h, actual %h",
                   $time, want.pixel, out_pixel);
          mismatch_count++;
        end
        if (out_row_end !== want.row_end) begin
          $display("%0t: row_end mismatch, expected %b, actual %b",
                   $time, want.row_end, out_row_end);
          mismatch_count++;
        end
      end
    end
  end

  // one source pixel through the model; returns 1 when a pixel comes out
  function automatic bit downscale_step(input logic [31:0] s, input logic fs,
                                        output out_pixel_t res);
    int unsigned               w;
    int unsigned               x;
    int unsigned               ow;
    int unsigned               idx;
    bit                        row_last;
    bit                        emit;
    logic [tdae_pkg::PS_W-1:0] ps;
    logic [tdae_pkg::PS_W-1:0] up;
    logic [9:0]                sum;
    w = (width_q == 0 || width_q > SRC_MAX) ? SRC_MAX : width_q;
    emit = 1'b0;
    res.pixel = '0;
    res.row_end = 1'b0;
    if (fs) begin
      col_q = '0;
      odd_q = 1'b0;
    end
    x = col_q;
    row_last = (x >= w - 1);
    if (mode_q == tdae_pkg::MODE_ALPHA_FULL) begin
      res.pixel = tdae_pkg::ALPHA_WHITE | {(present_q ? s[7:0] : 8'h00), 24'h0};
      res.row_end = row_last;
      emit = 1'b1;
    end else begin
      ow = w / 2;
      idx = x / 2;
      if (idx < ow && x % 2 == 0) begin
        left_q = s;
      end else if (idx < ow) begin
        ps = '0;
        if (mode_q == tdae_pkg::MODE_ALPHA_HALF) begin
          ps[tdae_pkg::LANE_W-1:0] = {1'b0, left_q[7:0]} + {1'b0, s[7:0]};
        end else begin
          for (int c = 0; c < 4; c++)
            ps[c*tdae_pkg::LANE_W +: tdae_pkg::LANE_W] =
              {1'b0, left_q[c*8 +: 8]} + {1'b0, s[c*8 +: 8]};
        end
        if (!odd_q) begin
          pair_sums[idx] = ps;
        end else begin
          up = pair_sums[idx];
          if (mode_q == tdae_pkg::MODE_ALPHA_HALF) begin
            sum = {1'b0, up[tdae_pkg::LANE_W-1:0]} + {1'b0, ps[tdae_pkg::LANE_W-1:0]};
            res.pixel = tdae_pkg::ALPHA_WHITE | {(present_q ? sum[9:2] : 8'h00), 24'h0};
          end else begin
            for (int c = 0; c < 4; c++) begin
              sum = {1'b0, up[c*tdae_pkg::LANE_W +: tdae_pkg::LANE_W]} +
                    {1'b0, ps[c*tdae_pkg::LANE_W +: tdae_pkg::LANE_W]};
              res.pixel[c*8 +: 8] = sum[9:2];
            end
          end
          res.row_end = (idx == ow - 1);
          emit = 1'b1;
        end
      end
    end
    if (row_last) begin
      col_q = '0;
      odd_q = ~odd_q;
    end else begin
      col_q = col_q + 12'd1;
    end
    return emit;
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic [31:0] s, input logic fs);
    out_pixel_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_frame_start <= fs;
    do @(posedge clk); while (in_stall);
    if (downscale_step(s, fs, res)) pending_pixels.push_back(res);
    sent_count++;
  endtask

  // a frame starts with frame_start; noisy frames get stray restarts and may stop early
  task automatic send_frame(input int unsigned rows, input int unsigned cols,
                            input bit noisy);
    int unsigned total;
    logic        fs;
    total = rows * cols;
    if (noisy) total = $urandom_range(1, total);
    for (int unsigned n = 0; n < total; n++) begin
      fs = (n == 0) || (noisy && $urandom_range(99) < 4);
      send_request(rand_sample(), fs);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tdae_pkg::REG_MODE:    mode_q = val[1:0];
      tdae_pkg::REG_WIDTH:   width_q = val;
      tdae_pkg::REG_PRESENT: present_q = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // unused upper data bits are filled with noise
  task automatic configure(input logic [1:0] m, input logic [CFG_W-1:0] w,
                           input logic p);
    logic [31:0] junk;
    junk = $urandom;
    wait_idle();
    write_reg(tdae_pkg::REG_MODE, {junk[CFG_W-3:0], m});
    write_reg(tdae_pkg::REG_WIDTH, w);
    write_reg(tdae_pkg::REG_PRESENT, {junk[CFG_W+9:11], p});
  endtask

  task automatic test_rgba_average();
    configure(tdae_pkg::MODE_RGBA_HALF, 13'd2, 1'b1);
    send_request(32'hffff_ffff, 1'b1);
    repeat (3) send_request(32'hffff_ffff, 1'b0);
    send_request(32'h0000_0000, 1'b1);
    send_request(32'h0102_0304, 1'b0);
    send_request(32'hfffe_fdfc, 1'b0);
    send_request(32'h0000_0001, 1'b0);
  endtask

  task automatic test_odd_edges();
    configure(MODE_RGBA_ALIAS, 13'd3, 1'b0);
    send_frame(3, 3, 1'b0);
    configure(tdae_pkg::MODE_ALPHA_HALF, 13'd1, 1'b1);
    send_frame(3, 1, 1'b0);
  endtask

  task automatic test_alpha_expand();
    configure(tdae_pkg::MODE_ALPHA_FULL, 13'd2, 1'b1);
    send_request(32'h1234_5600, 1'b1);
    send_request(32'habcd_efff, 1'b0);
    configure(tdae_pkg::MODE_ALPHA_FULL, 13'd2, 1'b0);
    send_request(32'h0000_00ff, 1'b1);
    send_request(32'hffff_ff80, 1'b0);
    configure(tdae_pkg::MODE_ALPHA_HALF, 13'd2, 1'b0);
    send_request(32'hffff_ffff, 1'b1);
    repeat (3) send_request(32'hffff_ffff, 1'b0);
  endtask

  // width drops below the current column mid-row: next request closes the row
  task automatic test_width_shrink();
    configure(tdae_pkg::MODE_ALPHA_FULL, 13'd8, 1'b1);
    send_frame(1, 5, 1'b0);
    configure(tdae_pkg::MODE_ALPHA_FULL, 13'd3, 1'b1);
    send_request(rand_sample(), 1'b0);
    send_request(rand_sample(), 1'b0);
  endtask

  // widest settings, only the start of a row
  task automatic test_width_extremes();
    configure(tdae_pkg::MODE_ALPHA_FULL, CFG_W'(SRC_MAX), 1'b1);
    send_frame(1, EXTREME_COLS, 1'b0);
    configure(tdae_pkg::MODE_ALPHA_FULL, '0, 1'b1);
    send_frame(1, EXTREME_COLS, 1'b0);
    configure(tdae_pkg::MODE_ALPHA_FULL, '1, 1'b0);
    send_frame(1, EXTREME_COLS, 1'b0);
  endtask

  task automatic test_random_frames(input int unsigned snd_pct, input int unsigned rcv_pct);
    int unsigned      stop_at;
    logic [CFG_W-1:0] w;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    stop_at = sent_count + ROUND_REQUESTS;
    while (sent_count < stop_at) begin
      case ($urandom_range(9))
        0: w = 13'd1;
        1: w = 13'd2;
        2: w = 13'd3;
        default: w = CFG_W'($urandom_range(2, 24));
      endcase
      configure(2'($urandom_range(3)), w, 1'($urandom_range(1)));
      repeat ($urandom_range(1, 3))
        send_frame($urandom_range(1, 5), w, $urandom_range(9) == 0);
    end
  endtask

  initial begin
    mode_q = tdae_pkg::RST_MODE;
    width_q = tdae_pkg::RST_WIDTH;
    present_q = tdae_pkg::RST_PRESENT;
    col_q = '0;
    odd_q = 1'b0;
    left_q = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 17;
    recv_idle_pct = 82;
    test_rgba_average();
    test_odd_edges();
    test_alpha_expand();
    test_width_shrink();
    test_width_extremes();
    test_random_frames(17, 82);
    test_random_frames(82, 17);
    test_random_frames(0, 0);
    wait_idle();
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("texture_downscale_alpha_expand test passed");
    end else begin
      $display("texture_downscale_alpha_expand test failed");
    end
    $finish;
  end

  initial begin
    #(10 * 1_000_000);
    $display("texture_downscale_alpha_expand test failed");
    $finish;
  end

endmodule
